/* rtl/core/ptmm_pkg.sv */
package ptmm_pkg;

    localparam int PAGES         = 64;
    localparam int PAGE_BYTES    = 256;
    localparam int POINTER_BASE  = 64;
    localparam int RAM_SIZE      = PAGES * PAGE_BYTES;
    localparam int TABLE_ENTRIES = (PAGES < PAGE_BYTES) ? PAGES : PAGE_BYTES;

    localparam int AW     = $clog2(RAM_SIZE);
    localparam int PAGE_W = $clog2(PAGES);
    localparam int OFF_W  = $clog2(PAGE_BYTES);
    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int ENT_W  = IDX_W + 1;
    localparam int SCAN_W = $clog2(PAGES + 1);
    localparam int DATA_W = 8;

    localparam int KIND_W   = 2;
    localparam int PROC_W   = 6;
    localparam int WANT_W   = 7;
    localparam int STATUS_W = 2;

    localparam logic [KIND_W-1:0] KIND_NEW   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_KILL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STORE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_TABLE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_DATA  = 2'd2;

    // Byte address of the first byte of a page; the page number wraps at the RAM size.
    function automatic logic [AW-1:0] page_base(input logic [DATA_W-1:0] pg);
        return {pg[PAGE_W-1:0], {OFF_W{1'b0}}};
    endfunction

endpackage

/* rtl/core/page_table_memory_manager.sv */
// Page-table memory manager over a 16 KiB byte RAM of 64 pages.
// Commands arrive on the req channel (req_valid/req_ready) and each item gives
// exactly one result item on the rsp channel (rsp_valid/rsp_ready).
// All work goes through one single-port RAM with a registered read, stepped by
// a small sequencer, so one command is handled at a time.
// Steps from acceptance to rsp_valid, with the receiver ready:
//   store and load read the process pointer, then the table entry, then
//   write or read the data byte; kill stops after the pointer read when it is
//   empty, else reads each of the 64 table entries and frees any page it names,
//   then frees the table page and clears the pointer;
//   new process: reads free-map bytes (at most 63 in all, since the scan
//   never restarts within a command), clears the table's 64 entries, and
//   spends one more write per data page taken. The next item can be accepted
//   in the cycle after a result is loaded.
// After reset the block sweeps the RAM once, one byte per cycle,
// writing zero everywhere and 1 into byte 0; req_ready stays low meanwhile.
// The result sits in an output register; a new item may be accepted while it
// waits, but that item's result is held back until rsp_ready takes the old one.
module page_table_memory_manager (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  logic [ptmm_pkg::KIND_W-1:0]      kind,
    input  logic [ptmm_pkg::PROC_W-1:0]      process,
    input  logic [ptmm_pkg::WANT_W-1:0]      pages_wanted,
    input  logic [ptmm_pkg::AW-1:0]          virtual_address,
    input  logic [ptmm_pkg::DATA_W-1:0]      store_data,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output logic [ptmm_pkg::STATUS_W-1:0]    status,
    output logic [ptmm_pkg::AW-1:0]          physical_address,
    output logic [ptmm_pkg::DATA_W-1:0]      load_data,
    output logic [ptmm_pkg::PAGE_W-1:0]      table_page
);

    localparam int AW     = ptmm_pkg::AW;
    localparam int DW     = ptmm_pkg::DATA_W;
    localparam int PW     = ptmm_pkg::PAGE_W;
    localparam int OW     = ptmm_pkg::OFF_W;
    localparam int IW     = ptmm_pkg::IDX_W;
    localparam int EW     = ptmm_pkg::ENT_W;
    localparam int SW     = ptmm_pkg::SCAN_W;
    localparam int STW    = ptmm_pkg::STATUS_W;
    localparam int WW     = ptmm_pkg::WANT_W;

    localparam int STATE_W = 4;
    localparam logic [STATE_W-1:0] S_CLEAR = 4'd0;
    localparam logic [STATE_W-1:0] S_IDLE  = 4'd1;
    localparam logic [STATE_W-1:0] S_SCAN  = 4'd2;
    localparam logic [STATE_W-1:0] S_SCHK  = 4'd3;
    localparam logic [STATE_W-1:0] S_TCLR  = 4'd4;
    localparam logic [STATE_W-1:0] S_ENTRY = 4'd5;
    localparam logic [STATE_W-1:0] S_PTRW  = 4'd6;
    localparam logic [STATE_W-1:0] S_PTR   = 4'd7;
    localparam logic [STATE_W-1:0] S_PCHK  = 4'd8;
    localparam logic [STATE_W-1:0] S_XCHK  = 4'd9;
    localparam logic [STATE_W-1:0] S_LWAIT = 4'd10;
    localparam logic [STATE_W-1:0] S_KRD   = 4'd11;
    localparam logic [STATE_W-1:0] S_KCHK  = 4'd12;
    localparam logic [STATE_W-1:0] S_KT    = 4'd13;
    localparam logic [STATE_W-1:0] S_KP    = 4'd14;
    localparam logic [STATE_W-1:0] S_DONE  = 4'd15;

    localparam logic [EW-1:0] LAST_ENT  = EW'(ptmm_pkg::TABLE_ENTRIES - 1);
    localparam logic [SW-1:0] SCAN_END  = SW'(ptmm_pkg::PAGES);
    localparam logic [WW-1:0] WANT_MAX  = WW'(ptmm_pkg::TABLE_ENTRIES);

    // Control state
    logic [STATE_W-1:0] state_reg, state_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic               rsp_valid_reg, rsp_valid_next;

    // Working registers of the current command
    logic [ptmm_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [ptmm_pkg::PROC_W-1:0] proc_reg, proc_next;
    logic [WW-1:0]      want_reg, want_next;
    logic [AW-1:0]      va_reg, va_next;
    logic [DW-1:0]      data_reg, data_next;
    logic [SW-1:0]      scan_reg, scan_next;
    logic               phase_tbl_reg, phase_tbl_next;
    logic [EW-1:0]      ent_reg, ent_next;
    logic [DW-1:0]      tbl_reg, tbl_next;
    logic [DW-1:0]      page_reg, page_next;
    logic [STW-1:0]     st_reg, st_next;
    logic [AW-1:0]      pa_reg, pa_next;
    logic [DW-1:0]      ld_reg, ld_next;

    // Output registers
    logic [STW-1:0]     status_reg, status_next;
    logic [AW-1:0]      phys_reg, phys_next;
    logic [DW-1:0]      load_reg, load_next;
    logic [PW-1:0]      tpage_reg, tpage_next;

    // RAM port
    logic [DW-1:0]      ram [ptmm_pkg::RAM_SIZE];
    logic [DW-1:0]      rd_q;
    logic [AW-1:0]      mem_addr;
    logic               mem_we;
    logic [DW-1:0]      mem_wd;

    logic [AW-1:0]      ptr_addr;
    logic [AW-1:0]      ent_addr;

    assign ptr_addr = AW'(ptmm_pkg::POINTER_BASE) + AW'(proc_reg);
    assign ent_addr = ptmm_pkg::page_base(tbl_reg) + AW'(ent_reg[IW-1:0]);

    assign req_ready        = (state_reg == S_IDLE);
    assign rsp_valid        = rsp_valid_reg;
    assign status           = status_reg;
    assign physical_address = phys_reg;
    assign load_data        = load_reg;
    assign table_page       = tpage_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        rsp_valid_next = rsp_valid_reg & ~rsp_ready;
        kind_next      = kind_reg;
        proc_next      = proc_reg;
        want_next      = want_reg;
        va_next        = va_reg;
        data_next      = data_reg;
        scan_next      = scan_reg;
        phase_tbl_next = phase_tbl_reg;
        ent_next       = ent_reg;
        tbl_next       = tbl_reg;
        page_next      = page_reg;
        st_next        = st_reg;
        pa_next        = pa_reg;
        ld_next        = ld_reg;
        status_next    = status_reg;
        phys_next      = phys_reg;
        load_next      = load_reg;
        tpage_next     = tpage_reg;
        mem_addr       = ptr_addr;
        mem_we         = 1'b0;
        mem_wd         = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_addr = clr_reg;
                mem_we   = 1'b1;
                mem_wd   = (clr_reg == '0) ? DW'(1) : '0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == {AW{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next      = kind;
                    proc_next      = process;
                    want_next      = (pages_wanted > WANT_MAX) ? WANT_MAX : pages_wanted;
                    va_next        = virtual_address;
                    data_next      = store_data;
                    scan_next      = SW'(1);
                    phase_tbl_next = 1'b1;
                    ent_next       = '0;
                    tbl_next       = '0;
                    st_next        = ptmm_pkg::STATUS_OK;
                    pa_next        = '0;
                    ld_next        = '0;
                    state_next     = (kind == ptmm_pkg::KIND_NEW) ? S_SCAN : S_PTR;
                end
            end
            S_SCAN:
            begin
                mem_addr = AW'(scan_reg);
                if (scan_reg == SCAN_END)
                begin
                    st_next    = phase_tbl_reg ? ptmm_pkg::STATUS_NO_TABLE
                                               : ptmm_pkg::STATUS_NO_DATA;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SCHK;
                end
            end
            S_SCHK:
            begin
                // Every page below the one found is in use, so the next scan
                // can resume right after it.
                mem_addr  = AW'(scan_reg);
                scan_next = scan_reg + SW'(1);
                if (rd_q == '0)
                begin
                    mem_we = 1'b1;
                    mem_wd = DW'(1);
                    if (phase_tbl_reg)
                    begin
                        tbl_next       = DW'(scan_reg);
                        phase_tbl_next = 1'b0;
                        ent_next       = '0;
                        state_next     = S_TCLR;
                    end
                    else
                    begin
                        page_next  = DW'(scan_reg);
                        state_next = S_ENTRY;
                    end
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_TCLR:
            begin
                mem_addr = ent_addr;
                mem_we   = 1'b1;
                mem_wd   = '0;
                ent_next = ent_reg + EW'(1);
                if (ent_reg == LAST_ENT)
                begin
                    ent_next   = '0;
                    state_next = (want_reg == '0) ? S_PTRW : S_SCAN;
                end
            end
            S_ENTRY:
            begin
                mem_addr   = ent_addr;
                mem_we     = 1'b1;
                mem_wd     = page_reg;
                ent_next   = ent_reg + EW'(1);
                state_next = (WW'(ent_reg) + WW'(1) == want_reg) ? S_PTRW : S_SCAN;
            end
            S_PTRW:
            begin
                mem_addr   = ptr_addr;
                mem_we     = 1'b1;
                mem_wd     = tbl_reg;
                state_next = S_DONE;
            end
            S_PTR:
            begin
                mem_addr   = ptr_addr;
                state_next = S_PCHK;
            end
            S_PCHK:
            begin
                tbl_next = rd_q;
                mem_addr = ptmm_pkg::page_base(rd_q) + AW'(va_reg[AW-1:OW]);
                if (kind_reg == ptmm_pkg::KIND_KILL)
                begin
                    ent_next   = '0;
                    state_next = (rd_q == '0) ? S_DONE : S_KRD;
                end
                else
                begin
                    state_next = S_XCHK;
                end
            end
            S_XCHK:
            begin
                mem_addr = {rd_q[PW-1:0], va_reg[OW-1:0]};
                pa_next  = {rd_q[PW-1:0], va_reg[OW-1:0]};
                if (kind_reg == ptmm_pkg::KIND_STORE)
                begin
                    mem_we     = 1'b1;
                    mem_wd     = data_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_LWAIT;
                end
            end
            S_LWAIT:
            begin
                ld_next    = rd_q;
                state_next = S_DONE;
            end
            S_KRD:
            begin
                mem_addr   = ent_addr;
                state_next = S_KCHK;
            end
            S_KCHK:
            begin
                // Freeing may touch the free map that later entries read when
                // the table wraps onto page 0; the read-then-write order keeps it exact.
                mem_addr = AW'(rd_q);
                mem_we   = (rd_q != '0);
                mem_wd   = '0;
                ent_next = ent_reg + EW'(1);
                state_next = (ent_reg == LAST_ENT) ? S_KT : S_KRD;
            end
            S_KT:
            begin
                mem_addr   = AW'(tbl_reg);
                mem_we     = 1'b1;
                mem_wd     = '0;
                state_next = S_KP;
            end
            S_KP:
            begin
                mem_addr   = ptr_addr;
                mem_we     = 1'b1;
                mem_wd     = '0;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    status_next    = st_reg;
                    phys_next      = pa_reg;
                    load_next      = ld_reg;
                    tpage_next     = tbl_reg[PW-1:0];
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        proc_reg      <= proc_next;
        want_reg      <= want_next;
        va_reg        <= va_next;
        data_reg      <= data_next;
        scan_reg      <= scan_next;
        phase_tbl_reg <= phase_tbl_next;
        ent_reg       <= ent_next;
        tbl_reg       <= tbl_next;
        page_reg      <= page_next;
        st_reg        <= st_next;
        pa_reg        <= pa_next;
        ld_reg        <= ld_next;
        status_reg    <= status_next;
        phys_reg      <= phys_next;
        load_reg      <= load_next;
        tpage_reg     <= tpage_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ram[mem_addr] <= mem_wd;
        end
        rd_q <= ram[mem_addr];
    end

endmodule

/* verif/page_table_checker.sv */
module page_table_checker
    import ptmm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_ready,
    input  logic [KIND_W-1:0]   kind,
    input  logic [PROC_W-1:0]   process_id,
    input  logic [WANT_W-1:0]   pages_wanted,
    input  logic [AW-1:0]       virtual_address,
    input  logic [DATA_W-1:0]   store_data,
    input  logic                rsp_valid,
    input  logic                rsp_ready,
    input  logic [STATUS_W-1:0] status,
    input  logic [AW-1:0]       physical_address,
    input  logic [DATA_W-1:0]   load_data,
    input  logic [PAGE_W-1:0]   table_page,
    output int                  failures,
    output int                  pending
);

    typedef struct packed {
        logic [STATUS_W-1:0] st;
        logic [AW-1:0]       pa;
        logic [DATA_W-1:0]   ld;
        logic [PAGE_W-1:0]   tp;
    } cmd_result_t;

    logic [DATA_W-1:0] mem_image [RAM_SIZE];
    cmd_result_t       expected_results [$];
    int                fail_total = 0;

    // Byte address inside a page; the page number wraps at the RAM size.
    function automatic logic [AW-1:0] byte_addr(input logic [DATA_W-1:0] pg, input int off);
        return AW'((int'(pg) * PAGE_BYTES + off) % RAM_SIZE);
    endfunction

    function automatic logic [DATA_W-1:0] grab_free_page();
        for (int j = 1; j < PAGES; j++)
        begin
            if (mem_image[j] == '0)
            begin
                mem_image[j] = DATA_W'(1);
                return DATA_W'(j);
            end
        end
        return '0;
    endfunction

    function automatic cmd_result_t run_command(
        input logic [KIND_W-1:0] k,
        input logic [PROC_W-1:0] proc,
        input logic [WANT_W-1:0] want,
        input logic [AW-1:0]     va,
        input logic [DATA_W-1:0] wdata
    );
        cmd_result_t       r;
        logic [DATA_W-1:0] tbl;
        logic [DATA_W-1:0] pg;
        logic [DATA_W-1:0] entry;
        logic [AW-1:0]     ptr;
        logic [AW-1:0]     pa;
        int                count;
        r = '0;
        ptr = AW'(POINTER_BASE + int'(proc));
        case (k)
            KIND_NEW:
            begin
                tbl = grab_free_page();
                if (tbl == '0)
                    r.st = STATUS_NO_TABLE;
                else
                begin
                    // Stale entries of a reused table page must not survive.
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                        mem_image[byte_addr(tbl, i)] = '0;
                    count = (int'(want) > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(want);
                    for (int i = 0; i < count && r.st == STATUS_OK; i++)
                    begin
                        pg = grab_free_page();
                        if (pg == '0)
                            r.st = STATUS_NO_DATA;
                        else
                            mem_image[byte_addr(tbl, i)] = pg;
                    end
                    if (r.st == STATUS_OK)
                        mem_image[ptr] = tbl;
                end
                r.tp = tbl[PAGE_W-1:0];
            end
            KIND_KILL:
            begin
                tbl = mem_image[ptr];
                if (tbl != '0)
                begin
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                    begin
                        pg = mem_image[byte_addr(tbl, i)];
                        if (pg != '0)
                            mem_image[AW'(pg)] = '0;
                    end
                    mem_image[AW'(tbl)] = '0;
                    mem_image[ptr] = '0;
                end
                r.tp = tbl[PAGE_W-1:0];
            end
            default:
            begin
                tbl = mem_image[ptr];
                entry = mem_image[byte_addr(tbl, int'(va) / PAGE_BYTES)];
                pa = byte_addr(entry, int'(va) % PAGE_BYTES);
                if (k == KIND_STORE)
                    mem_image[pa] = wdata;
                else
                    r.ld = mem_image[pa];
                r.pa = pa;
                r.tp = tbl[PAGE_W-1:0];
            end
        endcase
        return r;
    endfunction

    task automatic clear_image();
        foreach (mem_image[a])
            mem_image[a] = '0;
        mem_image[0] = DATA_W'(1);
        expected_results.delete();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cmd_result_t exp_r;
        cmd_result_t got_r;
        if (!rst_n)
        begin
            clear_image();
            pending <= 0;
        end
        else
        begin
            // Results are checked before the new item is predicted; a result can
            // never belong to an item accepted at the same edge.
            if (rsp_valid && rsp_ready)
            begin
                got_r = {status, physical_address, load_data, table_page};
                if (expected_results.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("unexpected result: status %0d pa %h load %h table %0d",
                                 status, physical_address, load_data, table_page);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (got_r !== exp_r)
                    begin
                        fail_total++;
                        if (fail_total <= 10)
                            $display({"result mismatch (expected/actual): status %0d/%0d ",
                                      "pa %h/%h load %h/%h table %0d/%0d"},
                                     exp_r.st, status, exp_r.pa, physical_address,
                                     exp_r.ld, load_data, exp_r.tp, table_page);
                    end
                end
            end
            if (req_valid && req_ready)
                expected_results.push_back(run_command(kind, process_id, pages_wanted,
                                                       virtual_address, store_data));
            pending <= expected_results.size();
            failures <= fail_total;
        end
    end

endmodule

/* verif/tb_page_table_memory_manager.sv */
module tb_page_table_memory_manager;
    import ptmm_pkg::*;

    localparam int PROCS            = 2 ** PROC_W;
    localparam int RANDOM_PER_PHASE = 125;
    localparam int PRESSURE_ITEMS   = 40;
    localparam int HOLD_CYCLES      = 1000;
    localparam int DRAIN_CYCLES     = 300;
    localparam int QUIET_LIMIT      = 60000;

    logic                clk              = 1'b0;
    logic                rst_n            = 1'b0;
    logic                req_valid        = 1'b0;
    logic                req_ready;
    logic [KIND_W-1:0]   kind             = KIND_NEW;
    logic [PROC_W-1:0]   process_id       = '0;
    logic [WANT_W-1:0]   pages_wanted     = '0;
    logic [AW-1:0]       virtual_address  = '0;
    logic [DATA_W-1:0]   store_data       = '0;
    logic                rsp_valid;
    logic                rsp_ready        = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [AW-1:0]       physical_address;
    logic [DATA_W-1:0]   load_data;
    logic [PAGE_W-1:0]   table_page;

    int failures;
    int pending;
    int idle_pct     = 0;
    int stall_pct    = 0;
    bit hold_req     = 1'b0;
    int hold_count   = 0;
    int quiet_cycles = 0;
    int items_sent   = 0;

    // Rough view of the allocation, used only to steer the stimulus.
    bit proc_live  [PROCS];
    int proc_pages [PROCS];
    int free_pages = PAGES - 1;

    page_table_memory_manager i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req_ready        (req_ready),
        .kind             (kind),
        .process          (process_id),
        .pages_wanted     (pages_wanted),
        .virtual_address  (virtual_address),
        .store_data       (store_data),
        .rsp_valid        (rsp_valid),
        .rsp_ready        (rsp_ready),
        .status           (status),
        .physical_address (physical_address),
        .load_data        (load_data),
        .table_page       (table_page)
    );

    page_table_checker i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req_ready        (req_ready),
        .kind             (kind),
        .process_id       (process_id),
        .pages_wanted     (pages_wanted),
        .virtual_address  (virtual_address),
        .store_data       (store_data),
        .rsp_valid        (rsp_valid),
        .rsp_ready        (rsp_ready),
        .status           (status),
        .physical_address (physical_address),
        .load_data        (load_data),
        .table_page       (table_page),
        .failures         (failures),
        .pending          (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Once asked for, the receiver holds off for a long stretch so the block backs up.
    always @(posedge clk)
    begin
        if (hold_req && hold_count < HOLD_CYCLES)
        begin
            hold_count++;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(99, 0) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Called right after a rising edge; returns at the edge that accepts the item.
    task automatic send_cmd(
        input logic [KIND_W-1:0] k,
        input logic [PROC_W-1:0] p,
        input logic [WANT_W-1:0] w,
        input logic [AW-1:0]     va,
        input logic [DATA_W-1:0] d
    );
        if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99, 0) < idle_pct);
        end
        req_valid       <= 1'b1;
        kind            <= k;
        process_id      <= p;
        pages_wanted    <= w;
        virtual_address <= va;
        store_data      <= d;
        do
            @(posedge clk);
        while (!req_ready);
        items_sent++;
    endtask

    task automatic touch_pages(input int p, input int accesses);
        int vpage;
        for (int a = 0; a < accesses; a++)
        begin
            // A process without data pages only reads; its stores would land in page 0.
            if (proc_pages[p] == 0)
                send_cmd(KIND_LOAD, PROC_W'(p), WANT_W'($urandom), AW'($urandom),
                         DATA_W'($urandom));
            else
            begin
                vpage = $urandom_range(proc_pages[p] - 1, 0);
                send_cmd(($urandom_range(1, 0) == 1) ? KIND_STORE : KIND_LOAD, PROC_W'(p),
                         WANT_W'($urandom), {PAGE_W'(vpage), OFF_W'($urandom)},
                         DATA_W'($urandom));
            end
        end
    endtask

    task automatic start_process(input int p);
        int cap;
        int w;
        cap = free_pages - 1;
        if ($urandom_range(9, 0) == 0)
            w = $urandom_range(cap, 0);
        else
            w = $urandom_range((cap < 6) ? cap : 6, 0);
        send_cmd(KIND_NEW, PROC_W'(p), WANT_W'(w), AW'($urandom), DATA_W'($urandom));
        proc_live[p]  = 1'b1;
        proc_pages[p] = w;
        free_pages    -= w + 1;
    endtask

    task automatic end_process(input int p);
        send_cmd(KIND_KILL, PROC_W'(p), WANT_W'($urandom), AW'($urandom), DATA_W'($urandom));
        if (proc_live[p])
        begin
            free_pages   += proc_pages[p] + 1;
            proc_live[p] = 1'b0;
        end
    endtask

    task automatic random_flow(input int n);
        int stop_at;
        int p;
        int q;
        int roll;
        stop_at = items_sent + n;
        while (items_sent < stop_at)
        begin
            roll = $urandom_range(99, 0);
            p = $urandom_range(PROCS - 1, 0);
            if (roll < 6)
                send_cmd(KIND_LOAD, PROC_W'(p), WANT_W'($urandom), AW'($urandom),
                         DATA_W'($urandom));
            else if (roll < 10)
                end_process(p);
            else if (proc_live[p])
            begin
                if (roll < 35)
                    end_process(p);
                else
                    touch_pages(p, $urandom_range(4, 1));
            end
            else if (free_pages > 0)
            begin
                start_process(p);
                touch_pages(p, $urandom_range(4, 1));
            end
            else
            begin
                q = $urandom_range(PROCS - 1, 0);
                while (!proc_live[q])
                    q = (q + 1) % PROCS;
                end_process(q);
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Out of data pages with a saturated request, then out of table pages.
        send_cmd(KIND_NEW,   6'd1,  7'd0,   14'd0,            8'h00);
        send_cmd(KIND_NEW,   6'd2,  7'd127, 14'd0,            8'h00);
        send_cmd(KIND_NEW,   6'd3,  7'd1,   14'd0,            8'h00);
        // An empty table entry maps to page 0, which lets the leaked table be
        // hooked to process 2 and then freed.
        send_cmd(KIND_STORE, 6'd1,  7'd0,   {6'd63, 8'd66},   8'd2);
        send_cmd(KIND_KILL,  6'd2,  7'd0,   14'd0,            8'h00);
        send_cmd(KIND_KILL,  6'd1,  7'd0,   14'd0,            8'h00);
        send_cmd(KIND_KILL,  6'd63, 7'd0,   14'd0,            8'h00);
        // Process 0 has no table and translates through page 0.
        send_cmd(KIND_STORE, 6'd0,  7'd0,   14'h3FFF,         8'hFF);
        send_cmd(KIND_LOAD,  6'd0,  7'd0,   14'h3FFF,         8'h00);
        send_cmd(KIND_LOAD,  6'd0,  7'd0,   14'd0,            8'h00);
        // One process takes every page; a further one finds no table page.
        send_cmd(KIND_NEW,   6'd63, 7'd62,  14'd0,            8'h00);
        send_cmd(KIND_NEW,   6'd5,  7'd0,   14'd0,            8'h00);
        send_cmd(KIND_STORE, 6'd63, 7'd0,   {6'd61, 8'd255},  8'hA5);
        send_cmd(KIND_LOAD,  6'd63, 7'd0,   {6'd61, 8'd255},  8'h00);
        send_cmd(KIND_STORE, 6'd63, 7'd0,   {6'd62, 8'd200},  8'h5A);
        send_cmd(KIND_KILL,  6'd63, 7'd0,   14'd0,            8'h00);
        // Recreating a live process leaks its old pages; they are reclaimed by
        // pointing a spare process at the old table.
        send_cmd(KIND_NEW,   6'd4,  7'd2,   14'd0,            8'h00);
        send_cmd(KIND_STORE, 6'd4,  7'd0,   {6'd1, 8'd7},     8'h3C);
        send_cmd(KIND_NEW,   6'd4,  7'd1,   14'd0,            8'h00);
        send_cmd(KIND_LOAD,  6'd4,  7'd0,   {6'd1, 8'd7},     8'h00);
        send_cmd(KIND_STORE, 6'd4,  7'd0,   {6'd2, 8'd74},    8'd1);
        send_cmd(KIND_KILL,  6'd10, 7'd0,   14'd0,            8'h00);
        send_cmd(KIND_KILL,  6'd4,  7'd0,   14'd0,            8'h00);

        random_flow(RANDOM_PER_PHASE);
        idle_pct = 73;
        random_flow(RANDOM_PER_PHASE);
        idle_pct  = 0;
        stall_pct = 73;
        random_flow(RANDOM_PER_PHASE);
        idle_pct  = 16;
        stall_pct = 16;
        random_flow(RANDOM_PER_PHASE);
        idle_pct  = 0;
        stall_pct = 0;
        hold_req <= 1'b1;
        random_flow(PRESSURE_ITEMS);
        req_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
